// ----- rtl/core/assert_macros.svh -----
// assertion macros for the rtl of the projection block
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VMMP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define VMMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define VMMP_ASSERT_IMPL(lbl, ante, cons)
`define VMMP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/vmmp_pkg.sv -----
// types and constants of the volume max and mean projection block
// no dependencies
package vmmp_pkg;
	localparam int MAX_WIDTH    = 256;
	localparam int MAX_HEIGHT   = 256;
	localparam int MAX_CHANNELS = 2;

	localparam int PIX_W   = 16;
	localparam int MEAN_W  = 40;
	localparam int RECIP_W = 25;
	localparam int PROD_W  = PIX_W + RECIP_W;
	localparam int SUM_W   = PROD_W + 1;

	localparam int COL_AW   = $clog2(MAX_WIDTH);
	localparam int ROW_AW   = $clog2(MAX_HEIGHT);
	localparam int CHAN_AW  = $clog2(MAX_CHANNELS);
	localparam int PLANE_AW = CHAN_AW + ROW_AW + COL_AW;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_DEPTH  = 2'd2;
	localparam logic [RECIP_W-1:0]   RECIP_ONE        = 25'h100_0000;

	typedef struct packed {
		logic [2:0]  pad;
		logic        chan;
		logic [11:0] slice;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [15:0] pixel;
	} in_word_t;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [PIX_W-1:0]  max;
	} proj_entry_t;

	localparam int ENTRY_W = $bits(proj_entry_t);

	typedef struct packed {
		proj_entry_t yz;
		proj_entry_t xz;
		proj_entry_t xy;
	} out_word_t;

	localparam int IN_W  = $bits(in_word_t);
	localparam int OUT_W = $bits(out_word_t);

	typedef struct packed {
		logic first;
		logic hit;
	} upd_ctl_t;
endpackage

// ----- rtl/core/vmmp_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module vmmp_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 56
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);
	logic [DATA_W-1:0] mem [(1 << ADDR_W)];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end
endmodule

// ----- rtl/core/vmmp_update.sv -----
// update of one projection entry: forward, restart, max and saturating mean
// depends on vmmp_pkg
module vmmp_update (
	input  logic [vmmp_pkg::PIX_W-1:0]  pixel,
	input  logic [vmmp_pkg::PROD_W-1:0] prod,
	input  vmmp_pkg::proj_entry_t       rd_entry,
	input  vmmp_pkg::proj_entry_t       fwd_entry,
	input  vmmp_pkg::upd_ctl_t          ctl,
	output vmmp_pkg::proj_entry_t       new_entry
);
	import vmmp_pkg::*;

	proj_entry_t      base;
	logic [SUM_W-1:0] sum;

	always_comb begin
		priority if (ctl.first) begin
			base = '0;
		end else if (ctl.hit) begin
			base = fwd_entry;
		end else begin
			base = rd_entry;
		end
		sum = SUM_W'(base.mean) + SUM_W'(prod);
		new_entry.mean = (|sum[SUM_W-1:MEAN_W]) ? '1 : sum[MEAN_W-1:0];
		new_entry.max  = (base.max < pixel) ? pixel : base.max;
	end
endmodule

// ----- rtl/core/volume_max_mean_projection_top.sv -----
// Volume max and mean projection.
// Pixels enter on s_axis, one word per pixel (pixel, col, row, slice, chan).
// Each accepted word yields one m_axis word with the six updated
// projection values: xy, xz and yz maximum and Q16.24 mean.
// The per-channel xy plane and the xz and yz rows live in three rams
// with registered read; each pixel reads its entries on accept,
// updates them in stage one and writes them back as it leaves.
// The pixel is registered in stage one on accept and its result in the
// output register when stage one advances. Throughput: one pixel per cycle
// while m_axis does not stall, also when consecutive pixels hit the same
// entry; the last written entries are forwarded from the output register.
// cfg writes the three Q1.24 reciprocals (index 0 width, 1 height,
// 2 depth); it is always ready, unknown indexes are dropped.
// Reset sets the reciprocals to 1.0 and empties the pipeline; the rams
// are not cleared and hold nothing useful until written.
// When m_axis stalls the output word holds, stage one keeps one more
// pixel and s_axis_tready drops only when both are full.
// depends on vmmp_pkg, vmmp_ram, vmmp_update, assert_macros.svh
`include "assert_macros.svh"
module volume_max_mean_projection_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// pixel, col, row, slice, chan, zero pad
	input  logic [vmmp_pkg::IN_W-1:0]         s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// xy_max, xy_mean, xz_max, xz_mean, yz_max, yz_mean
	output logic [vmmp_pkg::OUT_W-1:0]        m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vmmp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vmmp_pkg::RECIP_W-1:0]      cfg_data
);
	import vmmp_pkg::*;

	logic [RECIP_W-1:0] recip_width_q, recip_height_q, recip_depth_q;

	in_word_t           in_w;
	logic               acc;
	logic               s1_adv;
	logic [PLANE_AW-1:0] plane_addr;

	logic                s1_valid_q;
	logic [PIX_W-1:0]    pix_s1;
	logic [PROD_W-1:0]   prod_xy_s1, prod_xz_s1, prod_yz_s1;
	logic                first_xy_s1, first_xz_s1, first_yz_s1;
	logic [PLANE_AW-1:0] plane_addr_s1;
	logic [COL_AW-1:0]   col_s1;
	logic [ROW_AW-1:0]   row_s1;

	logic                lw_valid_q;
	logic [PLANE_AW-1:0] lw_plane_q;
	logic [COL_AW-1:0]   lw_col_q;
	logic [ROW_AW-1:0]   lw_row_q;

	logic                out_valid_q;
	out_word_t           out_data_q;

	logic [ENTRY_W-1:0]  rd_xy, rd_xz, rd_yz;
	upd_ctl_t            ctl_xy, ctl_xz, ctl_yz;
	proj_entry_t         new_xy, new_xz, new_yz;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_width_q  <= RECIP_ONE;
			recip_height_q <= RECIP_ONE;
			recip_depth_q  <= RECIP_ONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RECIP_WIDTH:  recip_width_q  <= cfg_data;
				REG_RECIP_HEIGHT: recip_height_q <= cfg_data;
				REG_RECIP_DEPTH:  recip_depth_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_w          = in_word_t'(s_axis_tdata);
	assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_adv;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign plane_addr    = {in_w.chan, in_w.row[ROW_AW-1:0], in_w.col[COL_AW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	// stage one payload, products formed on accept
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1        <= in_w.pixel;
			prod_xy_s1    <= PROD_W'(in_w.pixel) * PROD_W'(recip_depth_q);
			prod_xz_s1    <= PROD_W'(in_w.pixel) * PROD_W'(recip_height_q);
			prod_yz_s1    <= PROD_W'(in_w.pixel) * PROD_W'(recip_width_q);
			first_xy_s1   <= (in_w.slice == '0);
			first_xz_s1   <= (in_w.row == '0);
			first_yz_s1   <= (in_w.col == '0);
			plane_addr_s1 <= plane_addr;
			col_s1        <= in_w.col[COL_AW-1:0];
			row_s1        <= in_w.row[ROW_AW-1:0];
		end
	end

	vmmp_ram #(.ADDR_W(PLANE_AW), .DATA_W(ENTRY_W)) u_plane_ram (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (plane_addr),
		.rd_data (rd_xy),
		.wr_en   (s1_adv),
		.wr_addr (plane_addr_s1),
		.wr_data (new_xy)
	);

	vmmp_ram #(.ADDR_W(COL_AW), .DATA_W(ENTRY_W)) u_col_ram (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (in_w.col[COL_AW-1:0]),
		.rd_data (rd_xz),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (new_xz)
	);

	vmmp_ram #(.ADDR_W(ROW_AW), .DATA_W(ENTRY_W)) u_row_ram (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (in_w.row[ROW_AW-1:0]),
		.rd_data (rd_yz),
		.wr_en   (s1_adv),
		.wr_addr (row_s1),
		.wr_data (new_yz)
	);

	// the output word always holds the entries last written
	assign ctl_xy = '{first: first_xy_s1, hit: lw_valid_q && (lw_plane_q == plane_addr_s1)};
	assign ctl_xz = '{first: first_xz_s1, hit: lw_valid_q && (lw_col_q == col_s1)};
	assign ctl_yz = '{first: first_yz_s1, hit: lw_valid_q && (lw_row_q == row_s1)};

	vmmp_update u_upd_xy (
		.pixel     (pix_s1),
		.prod      (prod_xy_s1),
		.rd_entry  (proj_entry_t'(rd_xy)),
		.fwd_entry (out_data_q.xy),
		.ctl       (ctl_xy),
		.new_entry (new_xy)
	);

	vmmp_update u_upd_xz (
		.pixel     (pix_s1),
		.prod      (prod_xz_s1),
		.rd_entry  (proj_entry_t'(rd_xz)),
		.fwd_entry (out_data_q.xz),
		.ctl       (ctl_xz),
		.new_entry (new_xz)
	);

	vmmp_update u_upd_yz (
		.pixel     (pix_s1),
		.prod      (prod_yz_s1),
		.rd_entry  (proj_entry_t'(rd_yz)),
		.fwd_entry (out_data_q.yz),
		.ctl       (ctl_yz),
		.new_entry (new_yz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			lw_valid_q  <= 1'b0;
		end else begin
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				lw_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q.xy <= new_xy;
			out_data_q.xz <= new_xz;
			out_data_q.yz <= new_yz;
			lw_plane_q    <= plane_addr_s1;
			lw_col_q      <= col_s1;
			lw_row_q      <= row_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

	`VMMP_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_q && lw_valid_q)
	`VMMP_ASSERT_NEXT(a_row_forward, acc && s1_adv && (in_w.row[ROW_AW-1:0] == row_s1), ctl_yz.hit)
	`VMMP_ASSERT_NEXT(a_col_forward, acc && s1_adv && (in_w.col[COL_AW-1:0] == col_s1), ctl_xz.hit)
	`VMMP_ASSERT_IMPL(a_yz_restart_max, s1_valid_q && first_yz_s1, new_yz.max == pix_s1)
	`VMMP_ASSERT_IMPL(a_accept_room, acc, !s1_valid_q || s1_adv)
endmodule

// ----- bench/tb_volume_max_mean_projection_top.sv -----
`timescale 1ns / 100ps
// bench for volume_max_mean_projection_top: pixel words with random gaps and stalls,
// each output word checked field by field against a typed-in word or a bench predictor
// depends on vmmp_pkg and the rtl of the block
module tb_volume_max_mean_projection_top;
	import vmmp_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int RANDOM_PIXELS = 850;
	localparam int PHASES = 6;
	localparam int PLANE_N = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [MEAN_W-1:0] MEAN_CEIL = '1;
	localparam logic [RECIP_W-1:0] RECIP_FULL = '1;

	typedef struct packed {
		logic [15:0] pixel;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [11:0] slice;
		logic        chan;
		logic        typed;
		logic [15:0] xy_max;
		logic [39:0] xy_mean;
		logic [15:0] xz_max;
		logic [39:0] xz_mean;
		logic [15:0] yz_max;
		logic [39:0] yz_mean;
	} probe_t;

	// directed pixels, expected words typed in where obvious (weights at 1.0)
	probe_t probe_tab [14] = '{
		'{16'h1234, 8'd0, 8'd0, 12'd0, 1'b0, 1'b1,
			16'h1234, 40'h12_3400_0000, 16'h1234, 40'h12_3400_0000,
			16'h1234, 40'h12_3400_0000},
		'{16'hFFFF, 8'd1, 8'd0, 12'd0, 1'b0, 1'b1,
			16'hFFFF, 40'hFF_FF00_0000, 16'hFFFF, 40'hFF_FF00_0000,
			16'hFFFF, 40'hFF_FFFF_FFFF},
		'{16'h0000, 8'd0, 8'd1, 12'd0, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
		'{16'h0000, 8'd1, 8'd1, 12'd0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0},
		'{16'hFFFF, 8'd255, 8'd0, 12'd0, 1'b1, 1'b1,
			16'hFFFF, 40'hFF_FF00_0000, 16'hFFFF, 40'hFF_FF00_0000,
			16'hFFFF, 40'hFF_FFFF_FFFF},
		'{16'h0001, 8'd0, 8'd255, 12'd0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0},
		'{16'h8000, 8'd255, 8'd255, 12'd0, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
		'{16'h00FF, 8'd0, 8'd0, 12'd4095, 1'b0, 1'b1,
			16'h1234, 40'h13_3300_0000, 16'h00FF, 40'h00_FF00_0000,
			16'h00FF, 40'h00_FF00_0000},
		'{16'h0ABC, 8'd0, 8'd0, 12'd1, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
		'{16'hFFFF, 8'd255, 8'd0, 12'd4095, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0},
		'{16'h5555, 8'd255, 8'd255, 12'd2, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0},
		'{16'hAAAA, 8'd0, 8'd255, 12'd7, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0},
		'{16'h7FFF, 8'd1, 8'd1, 12'd3, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0},
		'{16'h0001, 8'd1, 8'd0, 12'd0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	in_word_t             s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RECIP_W-1:0]   cfg_data;

	logic [RECIP_W-1:0] weight_width = RECIP_ONE;
	logic [RECIP_W-1:0] weight_height = RECIP_ONE;
	logic [RECIP_W-1:0] weight_depth = RECIP_ONE;

	proj_entry_t plane_store [PLANE_N];
	proj_entry_t col_store [MAX_WIDTH];
	proj_entry_t row_store [MAX_HEIGHT];
	bit          plane_seen [PLANE_N];
	bit          col_seen [MAX_WIDTH];
	bit          row_seen [MAX_HEIGHT];

	out_word_t proj_due [$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        random_sent = 0;
	bit        calm = 1'b0;

	volume_max_mean_projection_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 14);
	end

	task automatic report_mismatch(string what, logic [MEAN_W-1:0] got, logic [MEAN_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
	endtask

	task automatic compare_field(string what, logic [MEAN_W-1:0] got, logic [MEAN_W-1:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		out_word_t got;
		out_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (proj_due.size() == 0) begin
				report_mismatch("word with nothing due", '0, '0);
			end else begin
				want = proj_due.pop_front();
				compare_field("xy_max", MEAN_W'(got.xy.max), MEAN_W'(want.xy.max));
				compare_field("xy_mean", got.xy.mean, want.xy.mean);
				compare_field("xz_max", MEAN_W'(got.xz.max), MEAN_W'(want.xz.max));
				compare_field("xz_mean", got.xz.mean, want.xz.mean);
				compare_field("yz_max", MEAN_W'(got.yz.max), MEAN_W'(want.yz.max));
				compare_field("yz_mean", got.yz.mean, want.yz.mean);
			end
		end
	end

	// max restarts from the pixel on first touch, mean from zero
	function automatic proj_entry_t fold_entry(proj_entry_t prev, bit first,
			logic [PIX_W-1:0] pix, logic [RECIP_W-1:0] weight);
		logic [63:0] acc;
		proj_entry_t nxt;
		acc = 64'(pix) * 64'(weight);
		if (!first)
			acc = acc + 64'(prev.mean);
		nxt.max = (first || pix > prev.max) ? pix : prev.max;
		nxt.mean = (acc > 64'(MEAN_CEIL)) ? MEAN_CEIL : acc[MEAN_W-1:0];
		return nxt;
	endfunction

	function automatic out_word_t project_pixel(in_word_t w);
		logic [PLANE_AW-1:0] at;
		out_word_t res;
		at = {w.chan, w.row, w.col};
		plane_store[at] = fold_entry(plane_store[at], w.slice == 0, w.pixel, weight_depth);
		col_store[w.col] = fold_entry(col_store[w.col], w.row == 0, w.pixel, weight_height);
		row_store[w.row] = fold_entry(row_store[w.row], w.col == 0, w.pixel, weight_width);
		plane_seen[at] = 1'b1;
		col_seen[w.col] = 1'b1;
		row_seen[w.row] = 1'b1;
		res.xy = plane_store[at];
		res.xz = col_store[w.col];
		res.yz = row_store[w.row];
		return res;
	endfunction

	// steer a random pixel away from entries never initialized
	function automatic in_word_t legal_noise(in_word_t w);
		while ((w.col != 0 && !row_seen[w.row]) || (w.row != 0 && !col_seen[w.col])) begin
			if (w.col != 0 && !row_seen[w.row])
				w.col = 0;
			else
				w.row = 0;
		end
		if (w.slice != 0 && !plane_seen[{w.chan, w.row, w.col}])
			w.slice = 0;
		return w;
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return PIX_W'($urandom);
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic push_pixel(in_word_t w, bit typed, out_word_t want);
		out_word_t pred;
		while (!calm && $urandom_range(0, 99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		do @(posedge clk); while (!s_axis_tready);
		pred = project_pixel(w);
		proj_due.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RECIP_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RECIP_WIDTH: weight_width = val;
			REG_RECIP_HEIGHT: weight_height = val;
			REG_RECIP_DEPTH: weight_depth = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		while (proj_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// one small volume in raster order, slice 0 first
	task automatic run_scan();
		int wd;
		int ht;
		int dp;
		bit dual;
		bit fixed_chan;
		logic [11:0] zval;
		in_word_t w;
		wd = $urandom_range(1, 6);
		ht = $urandom_range(1, 5);
		dp = $urandom_range(1, 3);
		dual = 1'($urandom_range(0, 1));
		fixed_chan = 1'($urandom_range(0, 1));
		for (int z = 0; z < dp; z++) begin
			zval = (z == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
			for (int y = 0; y < ht; y++) begin
				for (int x = 0; x < wd; x++) begin
					for (int c = 0; c <= int'(dual); c++) begin
						w.pad = '0;
						w.pixel = rand_pixel();
						w.col = 8'(x);
						w.row = 8'(y);
						w.slice = zval;
						w.chan = dual ? c[0] : fixed_chan;
						push_pixel(w, 1'b0, '0);
						random_sent++;
					end
				end
			end
		end
	endtask

	task automatic noise_burst();
		int n;
		in_word_t w;
		n = $urandom_range(1, 8);
		repeat (n) begin
			w.pad = '0;
			w.pixel = rand_pixel();
			w.col = 8'($urandom_range(0, 255));
			w.row = 8'($urandom_range(0, 255));
			w.slice = 12'($urandom_range(0, 4095));
			w.chan = 1'($urandom_range(0, 1));
			push_pixel(legal_noise(w), 1'b0, '0);
			random_sent++;
		end
	endtask

	initial begin
		in_word_t w;
		out_word_t want;
		int goal;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RECIP_WIDTH;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (probe_tab[i]) begin
			w.pad = '0;
			w.pixel = probe_tab[i].pixel;
			w.col = probe_tab[i].col;
			w.row = probe_tab[i].row;
			w.slice = probe_tab[i].slice;
			w.chan = probe_tab[i].chan;
			want.xy.max = probe_tab[i].xy_max;
			want.xy.mean = probe_tab[i].xy_mean;
			want.xz.max = probe_tab[i].xz_max;
			want.xz.mean = probe_tab[i].xz_mean;
			want.yz.max = probe_tab[i].yz_max;
			want.yz.mean = probe_tab[i].yz_mean;
			push_pixel(w, probe_tab[i].typed, want);
		end

		for (int p = 0; p < PHASES; p++) begin
			settle_idle();
			calm = (p == 3);
			case (p)
				0: begin
					write_reg(REG_RECIP_WIDTH, '0);
					write_reg(REG_RECIP_HEIGHT, RECIP_ONE);
					write_reg(REG_RECIP_DEPTH, RECIP_FULL);
				end
				1: begin
					write_reg(REG_RECIP_WIDTH, RECIP_FULL);
					write_reg(REG_RECIP_HEIGHT, RECIP_FULL);
					write_reg(REG_RECIP_DEPTH, RECIP_FULL);
					write_reg(REG_UNUSED, '0);
				end
				2: begin
					write_reg(REG_UNUSED, RECIP_FULL);
					write_reg(REG_RECIP_WIDTH, '0);
					write_reg(REG_RECIP_HEIGHT, '0);
					write_reg(REG_RECIP_DEPTH, '0);
				end
				3: begin
					write_reg(REG_RECIP_WIDTH, RECIP_W'($urandom_range(0, RECIP_ONE)));
					write_reg(REG_RECIP_HEIGHT, RECIP_W'($urandom_range(0, RECIP_ONE)));
					write_reg(REG_RECIP_DEPTH, RECIP_W'($urandom_range(0, RECIP_ONE)));
				end
				4: begin
					write_reg(REG_RECIP_WIDTH, RECIP_W'($urandom));
					write_reg(REG_RECIP_HEIGHT, RECIP_W'($urandom));
					write_reg(REG_RECIP_DEPTH, RECIP_W'($urandom));
				end
				default: begin
					write_reg(REG_RECIP_WIDTH, RECIP_ONE);
					write_reg(REG_RECIP_HEIGHT, RECIP_ONE);
					write_reg(REG_RECIP_DEPTH, RECIP_ONE);
				end
			endcase
			cfg_valid <= 1'b0;
			goal = (p + 1) * RANDOM_PIXELS / PHASES;
			while (random_sent < goal) begin
				if ($urandom_range(0, 3) != 0)
					run_scan();
				else
					noise_burst();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (proj_due.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/vmmp_pkg.sv
rtl/core/vmmp_ram.sv
rtl/core/vmmp_update.sv
rtl/core/volume_max_mean_projection_top.sv
bench/tb_volume_max_mean_projection_top.sv
